/* rtl/core/atlc_pkg.sv */
// atlc_pkg: shared types, codes and constants of the traffic light controller
// no dependencies; imported by every module under rtl/core

package atlc_pkg;

    localparam int TIME_WIDTH = 20;
    localparam int REM_WIDTH  = 20;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    localparam logic [15:0] GREEN_TIME_RST      = 16'd8000;
    localparam logic [15:0] YELLOW_TIME_RST     = 16'd5000;
    localparam logic [15:0] RED_TIME_RST        = 16'd7000;
    localparam logic [15:0] CROSSING_TIME_RST   = 16'd8000;
    localparam logic [15:0] EXTENSION_TIME_RST  = 16'd8000;
    localparam logic [3:0]  EXTENSION_LIMIT_RST = 4'd3;
    localparam logic [8:0]  DETECT_DISTANCE_RST = 9'd20;
    localparam logic [7:0]  DEBOUNCE_TIME_RST   = 8'd20;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GREEN_TIME      = 4'd0,
        REG_YELLOW_TIME     = 4'd1,
        REG_RED_TIME        = 4'd2,
        REG_CROSSING_TIME   = 4'd3,
        REG_EXTENSION_TIME  = 4'd4,
        REG_EXTENSION_LIMIT = 4'd5,
        REG_DETECT_DISTANCE = 4'd6,
        REG_DEBOUNCE_TIME   = 4'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_GREEN  = 2'd0,
        PH_YELLOW = 2'd1,
        PH_RED    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CODE_NORMAL      = 3'd0,
        CODE_PED_REQ     = 3'd1,
        CODE_PED_CROSS   = 3'd2,
        CODE_VEHICLE     = 3'd3,
        CODE_EXTENDED    = 3'd4,
        CODE_CAP_FORCED  = 3'd5,
        CODE_INTERRUPTED = 3'd6
    } status_code_t;

    typedef struct packed {
        logic [15:0] green_time;
        logic [15:0] yellow_time;
        logic [15:0] red_time;
        logic [15:0] crossing_time;
        logic [15:0] extension_time;
        logic [3:0]  extension_limit;
        logic [8:0]  detect_distance;
        logic [7:0]  debounce_time;
    } cfg_t;

    typedef struct packed {
        logic       button_low;
        logic       distance_valid;
        logic [8:0] dist_cm;
    } item_t;

    typedef struct packed {
        phase_t                light;
        status_code_t          status_code;
        logic [REM_WIDTH-1:0]  remaining_ms;
        logic                  beep_pulse;
        logic                  vehicle_near;
    } result_t;

    typedef struct packed {
        phase_t                lamp_phase;
        logic [TIME_WIDTH-1:0] phase_elapsed;
        logic [TIME_WIDTH-1:0] phase_length;
        logic [3:0]            extensions_used;
        logic                  pedestrian_pending;
        logic                  extension_pending;
        status_code_t          status;
        logic                  btn_armed;
        logic [7:0]            debounce_count;
        logic                  extension_given;
        logic                  near_flag;
    } state_t;

endpackage

/* rtl/core/adaptive_traffic_light_controller.sv */
// adaptive_traffic_light_controller: top level with input word register,
// controller state, result register and handshakes
// depends on atlc_pkg, atlc_cfg, atlc_step
//
//   channel  | direction | handshake           | payload
//   s_       | in        | s_valid / s_ready   | button_low, distance_valid, dist_cm
//   m_       | out       | m_valid / m_ready   | light, status_code, remaining_ms,
//            |           |                     | beep_pulse, vehicle_near
//   cfg_     | in        | cfg_we (no wait)    | cfg_index, cfg_data
//
// one word per cycle sustained while m_ready is high; a word accepted into the input register moves
// through the tick logic into the result register and from there leaves m_
// a stalled m_ready holds the result register and the input register; s_ready drops
// only when both are full and the result is not taken
// reset (synchronous, aresetn low) loads register defaults and the green phase

module adaptive_traffic_light_controller import atlc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_button_low,
    input  logic                       s_distance_valid,
    input  logic [8:0]                 s_dist_cm,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_light,
    output logic [2:0]                 m_status_code,
    output logic [REM_WIDTH-1:0]       m_remaining_ms,
    output logic                       m_beep_pulse,
    output logic                       m_vehicle_near,

    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    state_t  state_reg;
    state_t  state_next;
    logic    advance;
    logic    s_accept;

    atlc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    atlc_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .item (in_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.lamp_phase         <= PH_GREEN;
            state_reg.phase_elapsed      <= '0;
            state_reg.phase_length       <= TIME_WIDTH'(GREEN_TIME_RST);
            state_reg.extensions_used    <= '0;
            state_reg.pedestrian_pending <= 1'b0;
            state_reg.extension_pending  <= 1'b0;
            state_reg.status             <= CODE_NORMAL;
            state_reg.btn_armed          <= 1'b1;
            state_reg.debounce_count     <= '0;
            state_reg.extension_given    <= 1'b0;
            state_reg.near_flag          <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.button_low     <= s_button_low;
            in_reg.distance_valid <= s_distance_valid;
            in_reg.dist_cm        <= s_dist_cm;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_light        = res_reg.light;
    assign m_status_code  = res_reg.status_code;
    assign m_remaining_ms = res_reg.remaining_ms;
    assign m_beep_pulse   = res_reg.beep_pulse;
    assign m_vehicle_near = res_reg.vehicle_near;

    // elapsed time stays inside the current phase
    a_elapsed_in_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase_elapsed == '0 || state_reg.phase_elapsed < state_reg.phase_length)
        else $error("phase_elapsed outside phase length");

    // a lamp change is only reported with zero time left
    a_change_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (state_reg.lamp_phase == $past(state_reg.lamp_phase))
                    || (res_reg.remaining_ms == '0))
        else $error("lamp changed with time left");

    // a waiting word is never dropped
    a_word_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input word lost");

    // state moves only when a word goes through
    a_state_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a word");

endmodule

/* rtl/core/atlc_cfg.sv */
// atlc_cfg: timing and threshold register file with reset defaults
// depends on atlc_pkg

module atlc_cfg import atlc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_GREEN_TIME:      cfg_next.green_time      = cfg_data;
                REG_YELLOW_TIME:     cfg_next.yellow_time     = cfg_data;
                REG_RED_TIME:        cfg_next.red_time        = cfg_data;
                REG_CROSSING_TIME:   cfg_next.crossing_time   = cfg_data;
                REG_EXTENSION_TIME:  cfg_next.extension_time  = cfg_data;
                REG_EXTENSION_LIMIT: cfg_next.extension_limit = cfg_data[3:0];
                REG_DETECT_DISTANCE: cfg_next.detect_distance = cfg_data[8:0];
                REG_DEBOUNCE_TIME:   cfg_next.debounce_time   = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.green_time      <= GREEN_TIME_RST;
            cfg_reg.yellow_time     <= YELLOW_TIME_RST;
            cfg_reg.red_time        <= RED_TIME_RST;
            cfg_reg.crossing_time   <= CROSSING_TIME_RST;
            cfg_reg.extension_time  <= EXTENSION_TIME_RST;
            cfg_reg.extension_limit <= EXTENSION_LIMIT_RST;
            cfg_reg.detect_distance <= DETECT_DISTANCE_RST;
            cfg_reg.debounce_time   <= DEBOUNCE_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/atlc_step.sv */
// atlc_step: one millisecond tick of debounce, sensing and lamp sequencing
// depends on atlc_pkg; purely combinational, state held by the top level

module atlc_step import atlc_pkg::*; (
    input  cfg_t    cfg,
    input  state_t  cur,
    input  item_t   item,
    output state_t  nxt,
    output result_t res
);

    logic [TIME_WIDTH:0]   ext_sum;
    logic [TIME_WIDTH-1:0] ext_len;
    logic [TIME_WIDTH:0]   elapsed_sum;
    logic [TIME_WIDTH-1:0] elapsed_inc;
    logic [TIME_WIDTH-1:0] red_cross_len;
    logic [TIME_WIDTH-1:0] rem;
    logic                  beep;
    logic                  end_now;

    // saturating adds on the incoming state
    assign ext_sum     = {1'b0, cur.phase_length} + (TIME_WIDTH + 1)'(cfg.extension_time);
    assign ext_len     = ext_sum[TIME_WIDTH] ? TIME_MAX : ext_sum[TIME_WIDTH-1:0];
    assign elapsed_sum = {1'b0, cur.phase_elapsed} + (TIME_WIDTH + 1)'(1);
    assign elapsed_inc = elapsed_sum[TIME_WIDTH] ? TIME_MAX : elapsed_sum[TIME_WIDTH-1:0];
    assign red_cross_len = TIME_WIDTH'({1'b0, cfg.red_time} + {1'b0, cfg.crossing_time});

    always_comb begin
        nxt     = cur;
        beep    = 1'b0;
        end_now = 1'b0;
        rem     = '0;

        // button debounce
        if (!item.button_low) begin
            nxt.btn_armed      = 1'b1;
            nxt.debounce_count = '0;
        end else if (cur.btn_armed) begin
            if (cur.debounce_count >= cfg.debounce_time) begin
                nxt.btn_armed          = 1'b0;
                nxt.debounce_count     = '0;
                nxt.status             = CODE_PED_REQ;
                nxt.pedestrian_pending = 1'b1;
                beep                   = 1'b1;
            end else begin
                nxt.debounce_count = cur.debounce_count + 8'd1;
            end
        end else begin
            nxt.debounce_count = '0;
        end

        // distance sensing
        if (item.distance_valid) begin
            if (item.dist_cm < cfg.detect_distance) begin
                nxt.near_flag = 1'b1;
                if (cur.lamp_phase == PH_GREEN && !cur.extension_given) begin
                    nxt.extension_given = 1'b1;
                    if (nxt.status == CODE_NORMAL || nxt.status == CODE_VEHICLE) begin
                        nxt.status = CODE_VEHICLE;
                    end
                    nxt.extension_pending = 1'b1;
                end
            end else begin
                nxt.near_flag       = 1'b0;
                nxt.extension_given = 1'b0;
                if (nxt.status == CODE_VEHICLE) begin
                    nxt.status = CODE_NORMAL;
                end
            end
        end

        // green handling of pending requests
        if (cur.lamp_phase == PH_GREEN) begin
            if (nxt.pedestrian_pending) begin
                nxt.pedestrian_pending = 1'b0;
                nxt.status             = CODE_INTERRUPTED;
                end_now                = 1'b1;
            end else if (nxt.extension_pending) begin
                nxt.extension_pending = 1'b0;
                if (cur.extensions_used < cfg.extension_limit) begin
                    nxt.extensions_used = cur.extensions_used + 4'd1;
                    nxt.phase_length    = ext_len;
                    nxt.status          = CODE_EXTENDED;
                end else begin
                    nxt.status = CODE_CAP_FORCED;
                    end_now    = 1'b1;
                end
            end
        end

        // phase timing
        nxt.phase_elapsed = elapsed_inc;
        if (end_now || elapsed_inc >= nxt.phase_length) begin
            nxt.phase_elapsed = '0;
            unique case (cur.lamp_phase)
                PH_GREEN: begin
                    nxt.lamp_phase   = PH_YELLOW;
                    nxt.phase_length = TIME_WIDTH'(cfg.yellow_time);
                end
                PH_YELLOW: begin
                    nxt.lamp_phase = PH_RED;
                    if (nxt.pedestrian_pending) begin
                        nxt.pedestrian_pending = 1'b0;
                        nxt.status             = CODE_PED_CROSS;
                        beep                   = 1'b1;
                        nxt.phase_length       = red_cross_len;
                    end else begin
                        nxt.status       = CODE_NORMAL;
                        nxt.phase_length = TIME_WIDTH'(cfg.red_time);
                    end
                end
                default: begin
                    nxt.pedestrian_pending = 1'b0;
                    nxt.status             = CODE_NORMAL;
                    nxt.extensions_used    = '0;
                    nxt.lamp_phase         = PH_GREEN;
                    nxt.phase_length       = TIME_WIDTH'(cfg.green_time);
                end
            endcase
        end else begin
            rem = nxt.phase_length - elapsed_inc;
        end

        res.light        = cur.lamp_phase;
        res.status_code  = nxt.status;
        res.remaining_ms = REM_WIDTH'(rem);
        res.beep_pulse   = beep;
        res.vehicle_near = nxt.near_flag;
    end

endmodule
